// ===== rtl/json_stream_tokenizer_top_macros.svh =====
`ifndef JSON_STREAM_TOKENIZER_TOP_MACROS_SVH
`define JSON_STREAM_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jst check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jst check failed");

`endif

// ===== rtl/jst_pkg.sv =====
package jst_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int STK_AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MAX_RES   = 4;

    typedef enum logic [3:0] {
        M_TOP, M_VAL, M_ARR1, M_OBJ1, M_KEY, M_COLON, M_AFTER, M_FIN,
        M_STR, M_ESC, M_HEX, M_LIT, M_NUM
    } mode_t;

    typedef enum logic [3:0] {
        EV_OBJ_OPEN, EV_ARR_OPEN, EV_OBJ_CLOSE, EV_ARR_CLOSE, EV_STR_BYTE,
        EV_KEY_BYTE, EV_STR_END, EV_KEY_END, EV_NUM_CHAR, EV_NUM_END,
        EV_NULL, EV_TRUE, EV_FALSE, EV_DONE, EV_ERROR
    } ev_t;

    localparam logic [4:0] E_NONE        = 5'd0;
    localparam logic [4:0] E_END_TOP     = 5'd1;
    localparam logic [4:0] E_UNEXPECTED  = 5'd2;
    localparam logic [4:0] E_LITERAL     = 5'd3;
    localparam logic [4:0] E_END_STR     = 5'd4;
    localparam logic [4:0] E_BAD_ESC     = 5'd5;
    localparam logic [4:0] E_END_HEX     = 5'd6;
    localparam logic [4:0] E_BAD_HEX     = 5'd7;
    localparam logic [4:0] E_BAD_NUM     = 5'd8;
    localparam logic [4:0] E_BAD_FRAC    = 5'd9;
    localparam logic [4:0] E_BAD_EXP     = 5'd10;
    localparam logic [4:0] E_COLON       = 5'd11;
    localparam logic [4:0] E_OBJ_SEP     = 5'd12;
    localparam logic [4:0] E_ARR_SEP     = 5'd13;
    localparam logic [4:0] E_KEY_QUOTE   = 5'd14;
    localparam logic [4:0] E_TRAILING    = 5'd15;
    localparam logic [4:0] E_END_OBJ     = 5'd16;
    localparam logic [4:0] E_END_ARR     = 5'd17;
    localparam logic [4:0] E_DEPTH       = 5'd18;
    localparam logic [4:0] E_END_ESC     = 5'd19;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        ev_t        ev;
        logic [7:0] data;
        logic [6:0] depth;
        logic [4:0] err;
        logic       last;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        return (sel == 2'd2) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            2'd0:    case (idx) 3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l";
                         3'd3: ch = "l"; default: ch = 8'h00; endcase
            2'd1:    case (idx) 3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u";
                         3'd3: ch = "e"; default: ch = 8'h00; endcase
            2'd2:    case (idx) 3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l";
                         3'd3: ch = "s"; 3'd4: ch = "e"; default: ch = 8'h00; endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/jst_stream_if.sv =====
interface jst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, output text_byte, output byte_present,
                    output end_of_text, input ready);
    modport sink (input valid, input text_byte, input byte_present,
                  input end_of_text, output ready);
endinterface

interface jst_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] data;
    logic [6:0] nest_depth;
    logic [4:0] error_code;
    logic       last_of_run;

    modport source (output valid, output event_res, output data, output nest_depth,
                    output error_code, output last_of_run, input ready);
    modport sink (input valid, input event_res, input data, input nest_depth,
                  input error_code, input last_of_run, output ready);
endinterface

// ===== rtl/json_stream_tokenizer_top.sv =====
// The first result of a transaction is offered in the cycle after it is accepted.
// Throughput: one input byte per cycle while each byte gives at most one result and the output is
// ready; a byte with more results holds the input while the result buffer drains one per cycle.
// The container stack is a one-bit memory read one level below the top every cycle.
// Reset is asynchronous and active low; the stack memory needs no clearing pass.
module json_stream_tokenizer_top (
    input logic       clk,
    input logic       rst_n,
    jst_in_if.sink    in_ch,
    jst_out_if.source out_ch
);
    import jst_pkg::*;

    res_t [MAX_RES-1:0] res;
    logic [2:0]         res_n;
    in_t                item;
    logic               accept;
    logic               in_rdy;
    logic               out_fire;

    res_t       buf_reg [MAX_RES];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] ptr_reg, ptr_next;

    assign item     = '{text_byte: in_ch.text_byte, byte_present: in_ch.byte_present,
                        end_of_text: in_ch.end_of_text};
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_rdy   = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ch.ready);
    assign accept   = in_ch.valid && in_rdy;
    assign in_ch.ready = in_rdy;

    jst_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .res    (res),
        .res_n  (res_n)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (accept && res_n != 3'd0)
        begin
            cnt_next = res_n;
            ptr_next = 2'd0;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 3'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            ptr_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_n != 3'd0)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_reg[i] <= res[i];
            end
        end
    end

    assign out_ch.valid       = (cnt_reg != 3'd0);
    assign out_ch.event_res   = 4'(buf_reg[ptr_reg].ev);
    assign out_ch.data        = buf_reg[ptr_reg].data;
    assign out_ch.nest_depth  = buf_reg[ptr_reg].depth;
    assign out_ch.error_code  = buf_reg[ptr_reg].err;
    assign out_ch.last_of_run = buf_reg[ptr_reg].last;

endmodule

// ===== rtl/jst_engine.sv =====
module jst_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  jst_pkg::in_t                   item,
    output jst_pkg::res_t [jst_pkg::MAX_RES-1:0] res,
    output logic [2:0]                     res_n
);
    import jst_pkg::*;

    typedef struct packed {
        mode_t              mode;
        logic [DEPTH_W-1:0] depth;
        logic [1:0]         lsel;
        logic [2:0]         lidx;
        logic [15:0]        hacc;
        logic [2:0]         hcnt;
        logic [2:0]         nphase;
        logic               inkey;
        logic               err;
        logic               top;
    } st_t;

    localparam st_t ST_RESET = '{mode: M_TOP, depth: '0, lsel: '0, lidx: '0, hacc: '0,
                                 hcnt: '0, nphase: '0, inkey: 1'b0, err: 1'b0,
                                 top: 1'b0};
    localparam logic [3:0] NP_END = 4'd8;

    logic kind_mem [MAX_DEPTH];
    logic below_reg;
    st_t  st_reg, st_next;
    logic              wr_en;
    logic [STK_AW-1:0] wr_addr;
    logic              wr_kind;
    logic [DEPTH_W:0]  rd_full;

    function automatic void put(inout res_t [MAX_RES-1:0] rr, inout logic [2:0] nn,
                                input ev_t ev, input logic [7:0] dat,
                                input logic [DEPTH_W-1:0] dep, input logic [4:0] code);
        if (nn < 3'(MAX_RES))
        begin
            rr[nn[1:0]] = '{ev: ev, data: dat, depth: 7'(dep), err: code, last: 1'b0};
            nn = nn + 3'd1;
        end
    endfunction

    always_comb
    begin
        st_t        s;
        res_t [MAX_RES-1:0] r;
        logic [2:0] n;
        logic [7:0] c;
        logic       redo, do_after, do_start, do_open, do_close, kind;
        logic [3:0] np, d4;
        logic       hex_ok;
        logic [15:0] hv;
        logic [1:0] ls;
        logic [2:0] li;
        ev_t        tev;
        s = st_reg;
        r = '0;
        n = 3'd0;
        c = item.text_byte;
        redo = 1'b0; do_after = 1'b0; do_start = 1'b0; do_open = 1'b0;
        do_close = 1'b0; kind = 1'b0;
        np = NP_END; d4 = 4'd0; hex_ok = 1'b0; hv = 16'd0; ls = 2'd0; li = 3'd0;
        wr_en = 1'b0; wr_addr = '0; wr_kind = 1'b0;
        tev = s.inkey ? EV_KEY_BYTE : EV_STR_BYTE;

        if (item.byte_present && !s.err && !(s.mode <= M_FIN && is_ws(c)))
        begin
            case (s.mode)
                M_TOP, M_VAL: do_start = 1'b1;
                M_ARR1:
                    if (c == "]")
                    begin
                        do_close = 1'b1; kind = 1'b1;
                    end
                    else
                        do_start = 1'b1;
                M_OBJ1:
                    if (c == "}")
                        do_close = 1'b1;
                    else if (c == "\"")
                    begin
                        s.inkey = 1'b1; s.mode = M_STR;
                    end
                    else
                    begin
                        put(r, n, EV_ERROR, 8'd0, s.depth, E_KEY_QUOTE); s.err = 1'b1;
                    end
                M_KEY:
                    if (c == "\"")
                    begin
                        s.inkey = 1'b1; s.mode = M_STR;
                    end
                    else
                    begin
                        put(r, n, EV_ERROR, 8'd0, s.depth, E_KEY_QUOTE); s.err = 1'b1;
                    end
                M_COLON:
                    if (c == ":")
                        s.mode = M_VAL;
                    else
                    begin
                        put(r, n, EV_ERROR, 8'd0, s.depth, E_COLON); s.err = 1'b1;
                    end
                M_AFTER: do_after = 1'b1;
                M_FIN:
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, E_TRAILING); s.err = 1'b1;
                end
                M_STR:
                    if (c == "\"")
                    begin
                        put(r, n, s.inkey ? EV_KEY_END : EV_STR_END, 8'd0, s.depth, E_NONE);
                        if (s.inkey)
                            s.mode = M_COLON;
                        else
                            s.mode = (s.depth != '0) ? M_AFTER : M_FIN;
                        s.inkey = 1'b0;
                    end
                    else if (c == "\\")
                        s.mode = M_ESC;
                    else
                        put(r, n, tev, c, s.depth, E_NONE);
                M_ESC:
                begin
                    s.mode = M_STR;
                    case (c)
                        "\"", "\\", "/": put(r, n, tev, c, s.depth, E_NONE);
                        "b": put(r, n, tev, 8'h08, s.depth, E_NONE);
                        "f": put(r, n, tev, 8'h0C, s.depth, E_NONE);
                        "n": put(r, n, tev, 8'h0A, s.depth, E_NONE);
                        "r": put(r, n, tev, 8'h0D, s.depth, E_NONE);
                        "t": put(r, n, tev, 8'h09, s.depth, E_NONE);
                        "u":
                        begin
                            s.hacc = 16'd0; s.hcnt = 3'd0; s.mode = M_HEX;
                        end
                        default:
                        begin
                            s.mode = M_ESC;
                            put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_ESC); s.err = 1'b1;
                        end
                    endcase
                end
                M_HEX:
                begin
                    if (is_digit(c))
                    begin
                        d4 = 4'(c - "0"); hex_ok = 1'b1;
                    end
                    else if (c inside {["a":"f"]})
                    begin
                        d4 = 4'(c - "a" + 8'd10); hex_ok = 1'b1;
                    end
                    else if (c inside {["A":"F"]})
                    begin
                        d4 = 4'(c - "A" + 8'd10); hex_ok = 1'b1;
                    end
                    if (!hex_ok)
                    begin
                        put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_HEX); s.err = 1'b1;
                    end
                    else
                    begin
                        s.hacc = {s.hacc[11:0], d4};
                        s.hcnt = s.hcnt + 3'd1;
                        if (s.hcnt >= 3'd4)
                        begin
                            s.hcnt = 3'd0;
                            s.mode = M_STR;
                            hv = s.hacc;
                            if (hv <= 16'h007F)
                                put(r, n, tev, hv[7:0], s.depth, E_NONE);
                            else if (hv <= 16'h07FF)
                            begin
                                put(r, n, tev, 8'hC0 | {3'b000, hv[10:6]}, s.depth, E_NONE);
                                put(r, n, tev, 8'h80 | {2'b00, hv[5:0]}, s.depth, E_NONE);
                            end
                            else
                            begin
                                put(r, n, tev, 8'hE0 | {4'b0000, hv[15:12]}, s.depth, E_NONE);
                                put(r, n, tev, 8'h80 | {2'b00, hv[11:6]}, s.depth, E_NONE);
                                put(r, n, tev, 8'h80 | {2'b00, hv[5:0]}, s.depth, E_NONE);
                            end
                        end
                    end
                end
                M_LIT:
                begin
                    ls = (s.lsel < 2'd3) ? s.lsel : 2'd0;
                    li = (s.lidx < lit_len(ls)) ? s.lidx : 3'd0;
                    if (c != lit_char(ls, li))
                    begin
                        put(r, n, EV_ERROR, 8'd0, s.depth, E_LITERAL); s.err = 1'b1;
                    end
                    else
                    begin
                        s.lidx = li + 3'd1;
                        if (s.lidx >= lit_len(ls))
                        begin
                            put(r, n, ev_t'(4'(EV_NULL) + {2'b00, ls}), 8'd0, s.depth, E_NONE);
                            s.lidx = 3'd0;
                            s.mode = (s.depth != '0) ? M_AFTER : M_FIN;
                        end
                    end
                end
                M_NUM:
                begin
                    case (s.nphase)
                        3'd0:
                            if (is_digit(c))
                                np = (c == "0") ? 4'd1 : 4'd2;
                            else
                            begin
                                np = 4'd0;
                                put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_NUM); s.err = 1'b1;
                            end
                        3'd1:
                            if (c == ".") np = 4'd3;
                            else if (c == "e" || c == "E") np = 4'd5;
                        3'd2:
                            if (is_digit(c)) np = 4'd2;
                            else if (c == ".") np = 4'd3;
                            else if (c == "e" || c == "E") np = 4'd5;
                        3'd3:
                            if (is_digit(c))
                                np = 4'd4;
                            else
                            begin
                                np = 4'd3;
                                put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_FRAC); s.err = 1'b1;
                            end
                        3'd4:
                            if (is_digit(c)) np = 4'd4;
                            else if (c == "e" || c == "E") np = 4'd5;
                        3'd5:
                            if (c == "+" || c == "-") np = 4'd6;
                            else if (is_digit(c)) np = 4'd7;
                            else
                            begin
                                np = 4'd5;
                                put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_EXP); s.err = 1'b1;
                            end
                        3'd6:
                            if (is_digit(c))
                                np = 4'd7;
                            else
                            begin
                                np = 4'd6;
                                put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_EXP); s.err = 1'b1;
                            end
                        default:
                            if (is_digit(c)) np = 4'd7;
                    endcase
                    if (np == NP_END)
                    begin
                        put(r, n, EV_NUM_END, 8'd0, s.depth, E_NONE);
                        s.mode = (s.depth != '0) ? M_AFTER : M_FIN;
                        redo = 1'b1;
                    end
                    else if (!s.err)
                    begin
                        s.nphase = np[2:0];
                        put(r, n, EV_NUM_CHAR, c, s.depth, E_NONE);
                    end
                end
                default:
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, E_UNEXPECTED); s.err = 1'b1;
                end
            endcase

            if (redo && !is_ws(c))
            begin
                if (s.mode == M_AFTER)
                    do_after = 1'b1;
                else
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, E_TRAILING); s.err = 1'b1;
                end
            end

            if (do_after)
            begin
                if (c == ",")
                    s.mode = s.top ? M_VAL : M_KEY;
                else if (!s.top && c == "}")
                    do_close = 1'b1;
                else if (s.top && c == "]")
                begin
                    do_close = 1'b1; kind = 1'b1;
                end
                else
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, s.top ? E_ARR_SEP : E_OBJ_SEP);
                    s.err = 1'b1;
                end
            end

            if (do_start)
            begin
                if (c == "{")
                    do_open = 1'b1;
                else if (c == "[")
                begin
                    do_open = 1'b1; kind = 1'b1;
                end
                else if (c == "\"")
                begin
                    s.inkey = 1'b0; s.mode = M_STR;
                end
                else if (c == "n" || c == "t" || c == "f")
                begin
                    s.lsel = (c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2;
                    s.lidx = 3'd1;
                    s.mode = M_LIT;
                end
                else if (c == "-" || is_digit(c))
                begin
                    s.nphase = (c == "-") ? 3'd0 : (c == "0") ? 3'd1 : 3'd2;
                    put(r, n, EV_NUM_CHAR, c, s.depth, E_NONE);
                    s.mode = M_NUM;
                end
                else
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, E_UNEXPECTED); s.err = 1'b1;
                end
            end

            if (do_open)
            begin
                if (s.depth >= DEPTH_W'(MAX_DEPTH))
                begin
                    put(r, n, EV_ERROR, 8'd0, s.depth, E_DEPTH); s.err = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = s.depth[STK_AW-1:0];
                    wr_kind = kind;
                    s.depth = s.depth + DEPTH_W'(1);
                    s.top = kind;
                    put(r, n, kind ? EV_ARR_OPEN : EV_OBJ_OPEN, 8'd0, s.depth, E_NONE);
                    s.mode = kind ? M_ARR1 : M_OBJ1;
                end
            end

            if (do_close)
            begin
                s.depth = s.depth - DEPTH_W'(1);
                put(r, n, kind ? EV_ARR_CLOSE : EV_OBJ_CLOSE, 8'd0, s.depth, E_NONE);
                s.top = (s.depth != '0) ? below_reg : 1'b0;
                s.mode = (s.depth != '0) ? M_AFTER : M_FIN;
            end
        end

        if (item.end_of_text)
        begin
            if (!s.err)
            begin
                case (s.mode)
                    M_FIN: put(r, n, EV_DONE, 8'd0, s.depth, E_NONE);
                    M_TOP: put(r, n, EV_ERROR, 8'd0, s.depth, E_END_TOP);
                    M_STR: put(r, n, EV_ERROR, 8'd0, s.depth, E_END_STR);
                    M_ESC: put(r, n, EV_ERROR, 8'd0, s.depth, E_END_ESC);
                    M_HEX: put(r, n, EV_ERROR, 8'd0, s.depth, E_END_HEX);
                    M_LIT: put(r, n, EV_ERROR, 8'd0, s.depth, E_LITERAL);
                    M_NUM:
                        if (s.nphase == 3'd0)
                            put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_NUM);
                        else if (s.nphase == 3'd3)
                            put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_FRAC);
                        else if (s.nphase == 3'd5 || s.nphase == 3'd6)
                            put(r, n, EV_ERROR, 8'd0, s.depth, E_BAD_EXP);
                        else
                        begin
                            put(r, n, EV_NUM_END, 8'd0, s.depth, E_NONE);
                            if (s.depth == '0)
                                put(r, n, EV_DONE, 8'd0, s.depth, E_NONE);
                            else
                                put(r, n, EV_ERROR, 8'd0, s.depth,
                                    s.top ? E_END_ARR : E_END_OBJ);
                        end
                    default: put(r, n, EV_ERROR, 8'd0, s.depth,
                                 s.top ? E_END_ARR : E_END_OBJ);
                endcase
            end
            s = ST_RESET;
        end

        if (n != 3'd0)
            r[2'(n - 3'd1)].last = 1'b1;

        res   = r;
        res_n = n;
        st_next = accept ? s : st_reg;
        wr_en = wr_en && accept;
    end

    assign rd_full = {1'b0, st_next.depth} - (DEPTH_W + 1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_RESET;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            kind_mem[wr_addr] <= wr_kind;
        below_reg <= kind_mem[rd_full[STK_AW-1:0]];
    end

endmodule

// ===== rtl/jst_checker.sv =====
`include "json_stream_tokenizer_top_macros.svh"

module jst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] event_res,
    input logic [7:0] data,
    input logic [6:0] nest_depth,
    input logic [4:0] error_code,
    input logic       last_of_run
);
    import jst_pkg::*;

    `JST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(event_res) && $stable(data) && $stable(error_code))

    `JST_ASSERT_NOW(a_err_code, out_valid,
        (event_res == 4'(EV_ERROR)) == (error_code != E_NONE))

    `JST_ASSERT_NOW(a_data_zero,
        out_valid && event_res != 4'(EV_STR_BYTE) && event_res != 4'(EV_KEY_BYTE)
        && event_res != 4'(EV_NUM_CHAR), data == 8'd0)

    `JST_ASSERT_NOW(a_run_blocks, out_valid && !last_of_run, !in_ready)

    `JST_ASSERT_NOW(a_depth_max, out_valid, nest_depth <= 7'(MAX_DEPTH))

endmodule

bind json_stream_tokenizer_top jst_checker u_jst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .event_res   (out_ch.event_res),
    .data        (out_ch.data),
    .nest_depth  (out_ch.nest_depth),
    .error_code  (out_ch.error_code),
    .last_of_run (out_ch.last_of_run)
);
